FILE: rtl/wli_pkg.sv
package wli_pkg;

    // Store sizing
    localparam int MAX_NODES = 16;
    localparam int PT_MAX    = 2 * MAX_NODES - 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int PT_AW     = $clog2(PT_MAX);
    localparam int PT_CW     = $clog2(PT_MAX + 2);

    // Datapath widths: points in units of 2^-17, term magnitude in Q.32
    localparam int PX_W    = 33;
    localparam int OPR_W   = 34;
    localparam int MAG_W   = 56;
    localparam int HALF_W  = 28;
    localparam int PROD_W  = MAG_W + OPR_W;
    localparam int DIV_CW  = $clog2(PROD_W + 1);
    localparam int ACC_W   = 64;
    localparam int VAL_W   = 48;

    localparam logic [MAG_W-1:0] TERM_LIMIT  = '1;
    localparam logic [MAG_W-1:0] OUT_POS_LIM = MAG_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [MAG_W-1:0] OUT_NEG_LIM = MAG_W'(48'h8000_0000_0000);

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_NODES = 3'd1;
    localparam logic [2:0] ST_ZERO_Q   = 3'd2;
    localparam logic [2:0] ST_REPEAT   = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] interp_value;
        logic        [2:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [OPR_W-1:0] num;
        logic [OPR_W-1:0] den;
    } t_sc_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] q;
        logic             ovf;
    } t_sc_rsp;

    typedef struct packed {
        logic ready;
        logic res_valid;
    } t_core_ctl;

    function automatic logic [OPR_W-1:0] sx34(input logic [PX_W-1:0] v);
        return {v[PX_W-1], v};
    endfunction

    function automatic logic [OPR_W-1:0] mag34(input logic [OPR_W-1:0] v);
        return v[OPR_W-1] ? (~v + OPR_W'(1)) : v;
    endfunction

endpackage

FILE: rtl/weighted_lagrange_interpolator_top.sv
// Load, clear and unknown beats leave the core idle; the input is ready again the next cycle.
// A query with N nodes works on P = 2N-1 points; each scaling holds the shared unit
// for its multiply, divide and done steps. No-node and zero-query results skip the
// computation and go straight to the result.
// One item is in work at a time; the input stalls until the result leaves the core.
// Synchronous active-low reset empties the node store and drops any pending result.
module weighted_lagrange_interpolator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wli_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wli_pkg::t_out_item o_out_data
);
    import wli_pkg::*;

    t_core_ctl  ctl;
    t_out_item  core_res;
    logic       res_take;
    logic       r_out_valid;
    t_out_item  r_out;

    wli_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in_data),
        .o_ctl       (ctl),
        .o_res       (core_res),
        .i_res_take  (res_take)
    );

    // Take a result when the output register is empty or draining
    assign res_take   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !ctl.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= ctl.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && ctl.res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.res_valid && res_take) |=> o_out_valid)
        else $error("result beat lost on the way out");

endmodule

FILE: rtl/wli_scale.sv
module wli_scale (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  wli_pkg::t_sc_req i_req,
    output wli_pkg::t_sc_rsp o_rsp
);
    import wli_pkg::*;

    typedef enum logic [4:0] {
        SC_IDLE = 5'b00001,
        SC_MLO  = 5'b00010,
        SC_MHI  = 5'b00100,
        SC_DIV  = 5'b01000,
        SC_DONE = 5'b10000
    } t_sc_state;

    t_sc_state            r_st, n_st;
    logic [MAG_W-1:0]     r_mag;
    logic [OPR_W-1:0]     r_num, r_den;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [OPR_W:0]       r_rem, n_rem;
    logic [MAG_W:0]       r_q, n_q;
    logic                 r_ovf, n_ovf;
    logic [DIV_CW-1:0]    r_cnt, n_cnt;

    logic [HALF_W-1:0]        mul_a;
    logic [HALF_W+OPR_W-1:0]  mul_p;
    logic [OPR_W:0]           rem_sh;
    logic                     ge;
    logic [MAG_W:0]           q_sh;
    logic                     can_start;

    // Accept a new operation when idle or in the done cycle
    assign can_start = (r_st == SC_IDLE) || (r_st == SC_DONE);

    // Share one 28x34 multiplier across both halves of the magnitude
    assign mul_a = (r_st == SC_MLO) ? r_mag[HALF_W-1:0] : r_mag[MAG_W-1:HALF_W];
    assign mul_p = mul_a * r_num;

    // One restoring divide step per cycle
    assign rem_sh = {r_rem[OPR_W-1:0], r_prod[PROD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign q_sh   = {r_q[MAG_W-1:0], ge};

    always_comb begin
        n_st   = r_st;
        n_prod = r_prod;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        case (r_st)
            SC_IDLE: begin
                if (i_start) begin
                    n_st = SC_MLO;
                end
            end
            SC_MLO: begin
                n_prod = PROD_W'(mul_p);
                n_st   = SC_MHI;
            end
            SC_MHI: begin
                n_prod = r_prod + (PROD_W'(mul_p) << HALF_W);
                n_rem  = '0;
                n_q    = '0;
                n_ovf  = 1'b0;
                n_cnt  = DIV_CW'(PROD_W);
                n_st   = SC_DIV;
            end
            SC_DIV: begin
                n_rem  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                n_q    = q_sh;
                n_ovf  = r_ovf | q_sh[MAG_W];
                n_prod = r_prod << 1;
                n_cnt  = r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    n_st = SC_DONE;
                end
            end
            SC_DONE: begin
                n_st = i_start ? SC_MLO : SC_IDLE;
            end
            default: begin
                n_st = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SC_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Latch operands on start and hold them otherwise; working registers take their next values
    always_ff @(posedge i_clk) begin
        if (i_start && can_start) begin
            r_mag <= i_req.mag;
            r_num <= i_req.num;
            r_den <= i_req.den;
        end
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_ovf  <= n_ovf;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = (r_st == SC_DONE);
    assign o_rsp.q    = r_ovf ? TERM_LIMIT : r_q[MAG_W-1:0];
    assign o_rsp.ovf  = r_ovf;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ((r_st == SC_IDLE) || (r_st == SC_DONE)))
        else $error("scale start while busy");

endmodule

FILE: rtl/wli_core.sv
module wli_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  wli_pkg::t_in_item   i_req,
    output wli_pkg::t_core_ctl  o_ctl,
    output wli_pkg::t_out_item  o_res,
    input  logic                i_res_take
);
    import wli_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_FILL_RD = 16'h0002,
        S_FILL_WN = 16'h0004,
        S_FILL_WM = 16'h0008,
        S_DI_A    = 16'h0010,
        S_DI_U    = 16'h0020,
        S_DJ_A    = 16'h0040,
        S_DJ_U    = 16'h0080,
        S_TI_A    = 16'h0100,
        S_TI_U    = 16'h0200,
        S_SC      = 16'h0400,
        S_TJ_A    = 16'h0800,
        S_TJ_U    = 16'h1000,
        S_ACC     = 16'h2000,
        S_FIN     = 16'h4000,
        S_RES     = 16'h8000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_k, n_k;
    logic [PX_W-1:0]         r_qx, n_qx;
    logic [31:0]             r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [PT_CW-1:0]        r_np, n_np, r_i, n_i, r_j, n_j;
    logic [PT_AW-1:0]        r_ra, n_ra;
    logic [PX_W-1:0]         r_xi, n_xi;
    logic [MAG_W-1:0]        r_m, n_m;
    logic                    r_neg, n_neg;
    logic                    r_second, n_second;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    t_out_item               r_res, n_res;

    // Node store and point table
    logic [31:0]             nx_mem [MAX_NODES];
    logic [31:0]             ny_mem [MAX_NODES];
    logic [31:0]             r_nx_q, r_ny_q;
    logic                    node_we;
    logic [PX_W-1:0]         px_mem [PT_MAX];
    logic [PX_W-1:0]         py_mem [PT_MAX];
    logic [PX_W-1:0]         r_px_q, r_py_q;
    logic                    pt_we;
    logic [PT_AW-1:0]        pt_wa;
    logic [PX_W-1:0]         pt_wx, pt_wy;

    logic                    sc_start;
    t_sc_req                 sc_req;
    t_sc_rsp                 sc_rsp;

    logic [OPR_W-1:0]        q_mag, diff_a, diff_b;
    logic [PT_CW-1:0]        jp1, ip1;
    logic [ACC_W-1:0]        acc_mag;
    logic [MAG_W-1:0]        acc_sh;

    wli_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sc_start),
        .i_req   (sc_req),
        .o_rsp   (sc_rsp)
    );

    assign q_mag   = mag34(sx34(r_qx));
    assign diff_a  = sx34(r_qx) - sx34(r_px_q);
    assign diff_b  = sx34(r_xi) - sx34(r_px_q);
    assign jp1     = r_j + PT_CW'(1);
    assign ip1     = r_i + PT_CW'(1);
    assign acc_mag = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign acc_sh  = MAG_W'(acc_mag >> 8);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_qx     = r_qx;
        n_prev_x = r_prev_x;
        n_prev_y = r_prev_y;
        n_np     = r_np;
        n_i      = r_i;
        n_j      = r_j;
        n_ra     = r_ra;
        n_xi     = r_xi;
        n_m      = r_m;
        n_neg    = r_neg;
        n_second = r_second;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_res    = r_res;
        node_we  = 1'b0;
        pt_we    = 1'b0;
        pt_wa    = PT_AW'(r_k);
        pt_wx    = {r_nx_q, 1'b0};
        pt_wy    = {r_ny_q, 1'b0};
        sc_start = 1'b0;
        sc_req.mag = r_m;
        sc_req.num = mag34(diff_a);
        sc_req.den = mag34(diff_b);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.req_type)
                        REQ_LOAD: begin
                            if (r_count < CNT_W'(MAX_NODES)) begin
                                node_we = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                        REQ_QUERY: begin
                            n_qx  = {i_req.query_x, 1'b0};
                            n_acc = '0;
                            n_ovf = 1'b0;
                            n_res.interp_value = '0;
                            n_k   = '0;
                            n_np  = PT_CW'({r_count, 1'b0}) - PT_CW'(1);
                            if (r_count == '0) begin
                                n_res.status = ST_NO_NODES;
                                n_state      = S_RES;
                            end else if (i_req.query_x == '0) begin
                                n_res.status = ST_ZERO_Q;
                                n_state      = S_RES;
                            end else begin
                                n_state = S_FILL_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL_RD: begin
                n_state = S_FILL_WN;
            end
            S_FILL_WN: begin
                // Write the node itself at point k
                pt_we = 1'b1;
                if (r_k == '0) begin
                    n_prev_x = r_nx_q;
                    n_prev_y = r_ny_q;
                    n_k      = CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_i     = '0;
                        n_ra    = '0;
                        n_state = S_TI_A;
                    end else begin
                        n_state = S_FILL_RD;
                    end
                end else begin
                    n_state = S_FILL_WM;
                end
            end
            S_FILL_WM: begin
                // Write the midpoint of nodes k-1 and k after the nodes
                pt_we    = 1'b1;
                pt_wa    = PT_AW'(PT_CW'(r_count) + PT_CW'(r_k) - PT_CW'(1));
                pt_wx    = {r_prev_x[31], r_prev_x} + {r_nx_q[31], r_nx_q};
                pt_wy    = {r_prev_y[31], r_prev_y} + {r_ny_q[31], r_ny_q};
                n_prev_x = r_nx_q;
                n_prev_y = r_ny_q;
                n_k      = r_k + CNT_W'(1);
                if (r_k + CNT_W'(1) == r_count) begin
                    n_i     = '0;
                    n_ra    = '0;
                    n_state = S_DI_A;
                end else begin
                    n_state = S_FILL_RD;
                end
            end
            S_DI_A: begin
                n_state = S_DI_U;
            end
            S_DI_U: begin
                n_xi    = r_px_q;
                n_j     = ip1;
                n_ra    = PT_AW'(ip1);
                n_state = S_DJ_A;
            end
            S_DJ_A: begin
                n_state = S_DJ_U;
            end
            S_DJ_U: begin
                // Compare point j against point i
                if (r_px_q == r_xi) begin
                    n_res.status = ST_REPEAT;
                    n_state      = S_RES;
                end else if (jp1 == r_np) begin
                    if (ip1 + PT_CW'(1) == r_np) begin
                        n_i     = '0;
                        n_ra    = '0;
                        n_state = S_TI_A;
                    end else begin
                        n_i     = ip1;
                        n_ra    = PT_AW'(ip1);
                        n_state = S_DI_A;
                    end
                end else begin
                    n_j     = jp1;
                    n_ra    = PT_AW'(jp1);
                    n_state = S_DJ_A;
                end
            end
            S_TI_A: begin
                n_state = S_TI_U;
            end
            S_TI_U: begin
                // Start the term at y_i and scale by |x_i|/|x|, twice over
                n_xi       = r_px_q;
                n_neg      = r_py_q[PX_W-1];
                n_second   = 1'b0;
                n_j        = (r_i == '0) ? PT_CW'(1) : '0;
                sc_start   = 1'b1;
                sc_req.mag = MAG_W'({mag34(sx34(r_py_q)), 15'b0});
                sc_req.num = mag34(sx34(r_px_q));
                sc_req.den = q_mag;
                n_state    = S_SC;
            end
            S_SC: begin
                if (sc_rsp.done) begin
                    n_m   = sc_rsp.q;
                    n_ovf = r_ovf | sc_rsp.ovf;
                    if (!r_second) begin
                        n_second   = 1'b1;
                        sc_start   = 1'b1;
                        sc_req.mag = sc_rsp.q;
                        sc_req.num = mag34(sx34(r_xi));
                        sc_req.den = q_mag;
                    end else if (r_j < r_np) begin
                        n_ra    = PT_AW'(r_j);
                        n_state = S_TJ_A;
                    end else begin
                        n_state = S_ACC;
                    end
                end
            end
            S_TJ_A: begin
                n_state = S_TJ_U;
            end
            S_TJ_U: begin
                // Scale by |x - x_j| / |x_i - x_j|, skip j == i
                sc_start = 1'b1;
                n_neg    = r_neg ^ diff_a[OPR_W-1] ^ diff_b[OPR_W-1];
                n_j      = (jp1 == r_i) ? (r_j + PT_CW'(2)) : jp1;
                n_state  = S_SC;
            end
            S_ACC: begin
                n_acc = r_neg ? (r_acc - ACC_W'(r_m)) : (r_acc + ACC_W'(r_m));
                n_i   = ip1;
                if (ip1 == r_np) begin
                    n_state = S_FIN;
                end else begin
                    n_ra    = PT_AW'(ip1);
                    n_state = S_TI_A;
                end
            end
            S_FIN: begin
                // Truncate to Q24.24 toward zero and clamp
                if (r_acc[ACC_W-1]) begin
                    if (acc_sh > OUT_NEG_LIM) begin
                        n_res.interp_value = OUT_NEG_LIM[VAL_W-1:0];
                        n_res.status       = ST_SAT;
                    end else begin
                        n_res.interp_value = ~acc_sh[VAL_W-1:0] + VAL_W'(1);
                        n_res.status       = r_ovf ? ST_SAT : ST_OK;
                    end
                end else begin
                    if (acc_sh > OUT_POS_LIM) begin
                        n_res.interp_value = OUT_POS_LIM[VAL_W-1:0];
                        n_res.status       = ST_SAT;
                    end else begin
                        n_res.interp_value = acc_sh[VAL_W-1:0];
                        n_res.status       = r_ovf ? ST_SAT : ST_OK;
                    end
                end
                n_state = S_RES;
            end
            S_RES: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_qx     <= n_qx;
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_np     <= n_np;
        r_i      <= n_i;
        r_j      <= n_j;
        r_ra     <= n_ra;
        r_xi     <= n_xi;
        r_m      <= n_m;
        r_neg    <= n_neg;
        r_second <= n_second;
        r_acc    <= n_acc;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
    end

    // Node store: write at the fill count, read at k
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            nx_mem[r_count[NODE_AW-1:0]] <= i_req.node_x;
            ny_mem[r_count[NODE_AW-1:0]] <= i_req.node_y;
        end
        r_nx_q <= nx_mem[r_k[NODE_AW-1:0]];
        r_ny_q <= ny_mem[r_k[NODE_AW-1:0]];
    end

    // Point table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            px_mem[pt_wa] <= pt_wx;
            py_mem[pt_wa] <= pt_wy;
        end
        r_px_q <= px_mem[r_ra];
        r_py_q <= py_mem[r_ra];
    end

    assign o_ctl.ready     = (r_state == S_IDLE);
    assign o_ctl.res_valid = (r_state == S_RES);
    assign o_res           = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("node count past store depth");

    a_mid_after_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL_WM) |-> (r_k != '0) && $past(r_state == S_FILL_WN))
        else $error("midpoint write without a preceding node");

endmodule

FILE: verif/tb.sv
module tb;
    import wli_pkg::*;

    localparam logic [MAG_W-1:0] MAG_CLAMP = '1;
    localparam longint VAL_HI = 64'sd140737488355327;
    localparam longint VAL_LO = -64'sd140737488355328;

    // Node store model, interpolation predictor and result check
    class interp_scoreboard;
        longint    xs[MAX_NODES];
        longint    ys[MAX_NODES];
        int        count;
        t_out_item pending_results[$];
        int        mismatches;
        int        matched;
        int        queries;

        function new();
            count = 0;
            mismatches = 0;
            matched = 0;
            queries = 0;
        endfunction

        function logic [63:0] abs64(input longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // mag * num / den, truncated, clamped to the term bound
        function logic [MAG_W-1:0] rescale(input logic [MAG_W-1:0] mag,
                                           input logic [63:0] num,
                                           input logic [63:0] den,
                                           inout bit over);
            logic [127:0] prod;
            logic [127:0] quo;
            if (mag == 0 || num == 0 || den == 0) return '0;
            prod = {72'd0, mag} * {64'd0, num};
            quo = prod / {64'd0, den};
            if (quo > {72'd0, MAG_CLAMP}) begin
                over = 1'b1;
                return MAG_CLAMP;
            end
            return quo[MAG_W-1:0];
        endfunction

        function t_out_item interpolate(input logic signed [31:0] query_x);
            longint         px[PT_MAX];
            longint         py[PT_MAX];
            longint         qx;
            longint         sum;
            longint         a;
            longint         b;
            longint         val;
            logic [MAG_W-1:0] m;
            bit             neg;
            bit             over;
            int             np;
            t_out_item      r;
            logic [2:0]     st;
            st = ST_OK;
            over = 1'b0;
            sum = 0;
            np = 2 * count - 1;
            qx = longint'(query_x) * 2;
            if (count == 0) st = ST_NO_NODES;
            else if (qx == 0) st = ST_ZERO_Q;
            else begin
                for (int i = 0; i < count; i++) begin
                    px[i] = xs[i] * 2;
                    py[i] = ys[i] * 2;
                end
                for (int i = 0; i + 1 < count; i++) begin
                    px[count+i] = xs[i] + xs[i+1];
                    py[count+i] = ys[i] + ys[i+1];
                end
                for (int i = 0; i < np; i++)
                    for (int j = i + 1; j < np; j++)
                        if (px[i] == px[j]) st = ST_REPEAT;
            end
            if (st != ST_OK) begin
                r.interp_value = '0;
                r.status = st;
                return r;
            end
            // Sum the weighted Lagrange terms in point order
            for (int i = 0; i < np; i++) begin
                m = MAG_W'(abs64(py[i]) << 15);
                neg = py[i] < 0;
                m = rescale(m, abs64(px[i]), abs64(qx), over);
                m = rescale(m, abs64(px[i]), abs64(qx), over);
                for (int j = 0; j < np; j++) begin
                    if (j != i) begin
                        a = qx - px[j];
                        b = px[i] - px[j];
                        m = rescale(m, abs64(a), abs64(b), over);
                        neg = neg ^ (a < 0) ^ (b < 0);
                    end
                end
                sum += neg ? -longint'({8'd0, m}) : longint'({8'd0, m});
            end
            if (sum < 0) val = -((-sum) >>> 8);
            else val = sum >>> 8;
            if (val > VAL_HI) begin
                val = VAL_HI;
                over = 1'b1;
            end else if (val < VAL_LO) begin
                val = VAL_LO;
                over = 1'b1;
            end
            r.interp_value = val[VAL_W-1:0];
            r.status = over ? ST_SAT : ST_OK;
            return r;
        endfunction

        function void note_request(input t_in_item it);
            case (it.req_type)
                REQ_LOAD: begin
                    if (count < MAX_NODES) begin
                        xs[count] = longint'(it.node_x);
                        ys[count] = longint'(it.node_y);
                        count++;
                    end
                end
                REQ_CLEAR: count = 0;
                REQ_QUERY: begin
                    pending_results = {pending_results, interpolate(it.query_x)};
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d",
                             got.interp_value, got.status);
                return;
            end
            want = pending_results.pop_front();
            if (got.interp_value !== want.interp_value || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                             want.interp_value, want.status, got.interp_value, got.status);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    interp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;

    weighted_lagrange_interpolator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // Present one request beat and hold it until accepted
    task automatic send_request(input t_in_item it);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(it);
        beats_sent++;
        if (beats_sent == 180) begin
            send_idle_pct = 47;
            recv_idle_pct = 17;
        end else if (beats_sent == 360) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic send_fields(input logic [1:0] req, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] q);
        t_in_item it;
        it.req_type = req;
        it.node_x = x;
        it.node_y = y;
        it.query_x = q;
        send_request(it);
    endtask

    task automatic load_node(input logic [31:0] x, input logic [31:0] y);
        send_fields(REQ_LOAD, x, y, $urandom());
    endtask

    task automatic query_at(input logic [31:0] q);
        send_fields(REQ_QUERY, $urandom(), $urandom(), q);
    endtask

    task automatic clear_nodes();
        send_fields(REQ_CLEAR, $urandom(), $urandom(), $urandom());
    endtask

    // Random-size node set, mostly small, then queries near, far or at zero
    task automatic random_sequence();
        int n;
        int nq;
        int sel;
        logic [31:0] base;
        if ($urandom_range(9) == 0) begin
            send_fields(REQ_RSVD, $urandom(), $urandom(), $urandom());
            return;
        end
        if ($urandom_range(4) != 0) clear_nodes();
        n = ($urandom_range(149) == 0) ? MAX_NODES + 1 : $urandom_range(1, 3);
        base = $urandom();
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(3);
            if (sel == 0) load_node($urandom(), $urandom());
            else load_node(base + $urandom_range(1, 1 << 18) * (k + 1), $urandom());
        end
        nq = $urandom_range(1, 3);
        for (int k = 0; k < nq; k++) begin
            sel = $urandom_range(4);
            if (sel == 0) query_at($urandom());
            else if (sel == 1) query_at(32'd0);
            else query_at(base + $urandom_range(0, 1 << 20));
        end
    endtask

    initial begin
        sb = new();
        send_idle_pct = 17;
        recv_idle_pct = 47;
        beats_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, zero query, repeated points, saturation
        query_at(32'h0001_0000);
        load_node(32'h0001_0000, 32'h7FFF_FFFF);
        query_at(32'd0);
        query_at(32'h0001_8000);
        load_node(32'h8000_0000, 32'h8000_0000);
        query_at(32'h7FFF_FFFF);
        query_at(32'h8000_0000);
        load_node(32'h0001_0000, 32'h0000_1000);
        query_at(32'h0002_0000);
        clear_nodes();
        load_node(32'h0000_0000, 32'h0001_0000);
        load_node(32'h0002_0000, 32'h0002_0000);
        load_node(32'h0001_0000, 32'h0003_0000);
        query_at(32'h0000_8000);
        clear_nodes();
        load_node(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_at(32'h0000_0001);
        send_fields(REQ_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        clear_nodes();
        // Fill past capacity; the extra load is dropped
        for (int k = 0; k <= MAX_NODES; k++)
            load_node(32'(k * 32'h0003_0000 + 32'h0000_1234), $urandom());
        query_at(32'h0010_0000);

        while (beats_sent < 500) random_sequence();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d request beats, %0d queries, %0d results matched",
                 beats_sent, sb.queries, sb.matched);
        $display("covered load, clear, ignored requests, overfull store and all status cases");
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[weighted_lagrange_interpolator_top] OK");
        end else begin
            $display("[weighted_lagrange_interpolator_top] ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout with %0d results outstanding", sb.pending_results.size());
        $display("[weighted_lagrange_interpolator_top] ERROR");
        $finish;
    end
endmodule

FILE: weighted_lagrange_interpolator_top.f
rtl/wli_pkg.sv
rtl/wli_scale.sv
rtl/wli_core.sv
rtl/weighted_lagrange_interpolator_top.sv
verif/tb.sv
